### design/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// shared types, token codes and keyword tables for the token scanner
// ----------------------------------------------------------------------------
package dts_pkg;

   localparam int DEF_LENGTH_BITS   = 8;
   localparam int DEF_POSITION_BITS = 16;

   localparam int RSP_DEPTH = 4;

   localparam int KW_COUNT  = 4;
   localparam int KW_SLOTS  = 8;
   localparam int KW_IDX_BITS = $clog2(KW_SLOTS);

   localparam logic [4:0] KIND_COMMA     = 5'd0;
   localparam logic [4:0] KIND_PERIOD    = 5'd1;
   localparam logic [4:0] KIND_QMARK     = 5'd2;
   localparam logic [4:0] KIND_LPAREN    = 5'd3;
   localparam logic [4:0] KIND_RPAREN    = 5'd4;
   localparam logic [4:0] KIND_COLON     = 5'd5;
   localparam logic [4:0] KIND_COLONDASH = 5'd6;
   localparam logic [4:0] KIND_MUL       = 5'd7;
   localparam logic [4:0] KIND_ADD       = 5'd8;
   localparam logic [4:0] KIND_KEYWORD0  = 5'd9;
   localparam logic [4:0] KIND_ID        = 5'd13;
   localparam logic [4:0] KIND_STRING    = 5'd14;
   localparam logic [4:0] KIND_END       = 5'd15;
   localparam logic [4:0] KIND_ERROR     = 5'd16;

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [7:0] CHAR_QMARK   = 8'h3F;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_QUOTE   = 8'h27;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // Queries, Facts, Rules, Schemes
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
      '{"Q", "u", "e", "r", "i", "e", "s", 8'h00},
      '{"F", "a", "c", "t", "s", 8'h00, 8'h00, 8'h00},
      '{"R", "u", "l", "e", "s", 8'h00, 8'h00, 8'h00},
      '{"S", "c", "h", "e", "m", "e", "s", 8'h00}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd7, 4'd5, 4'd5, 4'd7};

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] line;
      logic [15:0] start_offset;
      logic [7:0]  length;
      logic        last_of_item;
   } rsp_payload_type;

endpackage

### design/dts_stream_if.sv
// ----------------------------------------------------------------------------
// dts stream interfaces
// valid/ready channels for source bytes and emitted tokens
// ----------------------------------------------------------------------------
interface dts_req_if;
   import dts_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dts_rsp_if;
   import dts_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/datalog_token_scanner_core.sv
// ----------------------------------------------------------------------------
// datalog_token_scanner_core
// byte-at-a-time lexer for datalog source, emitting tokens with line,
// start offset and length
//
//   channel  dir  payload
//   req      in   character, end_of_input
//   rsp      out  token_kind, line, start_offset, length, last_of_item
//
// one source byte per cycle while req.ready is high: the scan state updates in the transfer cycle
// a byte gives zero, one or two tokens, pushed into a four-entry result queue
// req.ready is high while the queue has room for two tokens
// rsp stalls fill the queue and then hold req.ready low; sustained rate is one byte per cycle while the queue has room
// synchronous reset returns to line 1, offset 0, idle; no clearing pass
// ----------------------------------------------------------------------------
module datalog_token_scanner_core #(
   parameter int LENGTH_BITS   = dts_pkg::DEF_LENGTH_BITS,
   parameter int POSITION_BITS = dts_pkg::DEF_POSITION_BITS
) (
   input logic      clock,
   input logic      reset,
   dts_req_if.sink   req,
   dts_rsp_if.source rsp
);
   import dts_pkg::*;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_STRING  = 3'd2;
   localparam logic [2:0] MODE_COLON   = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;
   localparam logic [2:0] MODE_STOPPED = 3'd5;

   localparam int PtrBits = $clog2(RSP_DEPTH);

   logic [2:0]               mode_ff,  mode_in;
   logic [15:0]              line_ff,  line_in;
   logic [POSITION_BITS-1:0] pos_ff,   pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0]   len_ff,   len_in;
   logic [KW_COUNT-1:0]      flags_ff, flags_in;

   rsp_payload_type        fifo_ff [RSP_DEPTH];
   logic [PtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]       count_ff,  count_in;

   logic                   accept;
   logic                   pop;
   logic [7:0]             c;
   logic                   is_alpha;
   logic                   is_alnum;
   logic [15:0]            line_inc;
   logic [LENGTH_BITS-1:0] len_bump;
   logic [KW_COUNT-1:0]    flags_match;
   logic [KW_COUNT-1:0]    flags_first;
   logic [4:0]             ident_kind;
   logic                   use_idle;
   logic                   idle_e;
   rsp_payload_type        idle_r;
   logic                   e0, e1;
   rsp_payload_type        r0, r1;

   function automatic rsp_payload_type make_rsp(logic [4:0] kind, logic [15:0] ln,
                                                logic [POSITION_BITS-1:0] start,
                                                logic [LENGTH_BITS-1:0] len);
      rsp_payload_type r;
      r.token_kind   = kind;
      r.line         = ln;
      r.start_offset = 16'(start);
      r.length       = 8'(len);
      r.last_of_item = 1'b0;
      return r;
   endfunction

   assign accept    = req.valid && req.ready;
   assign req.ready = count_ff <= (PtrBits+1)'(RSP_DEPTH - 2);
   assign rsp.valid = count_ff != '0;
   assign rsp.payload = fifo_ff[rd_ptr_ff];
   assign pop       = rsp.valid && rsp.ready;

   assign c        = req.payload.character;
   assign is_alpha = (c inside {["A":"Z"], ["a":"z"]});
   assign is_alnum = is_alpha || (c inside {["0":"9"]});
   assign line_inc = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
   assign len_bump = (len_ff == '1) ? len_ff : len_ff + LENGTH_BITS'(1);

   // keyword tracking
   always_comb begin
      flags_match = flags_ff;
      flags_first = '0;
      ident_kind  = KIND_ID;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!(len_ff < LENGTH_BITS'(KW_LEN[k]) &&
               KW_TEXT[k][len_ff[KW_IDX_BITS-1:0]] == c)) begin
            flags_match[k] = 1'b0;
         end
         flags_first[k] = (KW_TEXT[k][0] == c);
      end
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (flags_ff[k] && len_ff == LENGTH_BITS'(KW_LEN[k])) begin
            ident_kind = 5'(KIND_KEYWORD0 + 5'(k));
         end
      end
   end

   // scan step
   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      flags_in = flags_ff;
      e0       = 1'b0;
      e1       = 1'b0;
      r0       = '0;
      r1       = '0;
      use_idle = 1'b0;
      idle_e   = 1'b0;
      idle_r   = '0;

      if (accept && mode_ff != MODE_STOPPED) begin
         if (req.payload.end_of_input) begin
            mode_in = MODE_STOPPED;
            if (mode_ff == MODE_STRING) begin
               e0 = 1'b1;
               r0 = make_rsp(KIND_ERROR, line_ff, pos_ff, '0);
            end else if (mode_ff == MODE_IDENT || mode_ff == MODE_COLON) begin
               e0 = 1'b1;
               r0 = (mode_ff == MODE_IDENT) ?
                    make_rsp(ident_kind, line_ff, start_ff, len_ff) :
                    make_rsp(KIND_COLON, line_ff, start_ff, LENGTH_BITS'(1));
               e1 = 1'b1;
               r1 = make_rsp(KIND_END, line_ff, pos_ff, '0);
            end else begin
               e0 = 1'b1;
               r0 = make_rsp(KIND_END, line_ff, pos_ff, '0);
            end
         end else begin
            pos_in = pos_ff + POSITION_BITS'(1);
            case (mode_ff)
               MODE_IDENT: begin
                  if (is_alnum) begin
                     flags_in = flags_match;
                     len_in   = len_bump;
                  end else begin
                     e0       = 1'b1;
                     r0       = make_rsp(ident_kind, line_ff, start_ff, len_ff);
                     use_idle = 1'b1;
                  end
               end
               MODE_COLON: begin
                  e0 = 1'b1;
                  if (c == CHAR_DASH) begin
                     r0      = make_rsp(KIND_COLONDASH, line_ff, start_ff, LENGTH_BITS'(2));
                     mode_in = MODE_IDLE;
                  end else begin
                     r0       = make_rsp(KIND_COLON, line_ff, start_ff, LENGTH_BITS'(1));
                     use_idle = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (c == CHAR_QUOTE) begin
                     len_in  = len_bump;
                     e0      = 1'b1;
                     r0      = make_rsp(KIND_STRING, line_ff, start_ff, len_bump);
                     mode_in = MODE_IDLE;
                  end else if (c == CHAR_NEWLINE) begin
                     e0      = 1'b1;
                     r0      = make_rsp(KIND_ERROR, line_ff, pos_ff, '0);
                     mode_in = MODE_STOPPED;
                  end else begin
                     len_in = len_bump;
                  end
               end
               MODE_COMMENT: begin
                  if (c == CHAR_NEWLINE) begin
                     line_in = line_inc;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_IDLE: begin
                  use_idle = 1'b1;
               end
               default: begin
                  mode_in = MODE_STOPPED;
               end
            endcase

            if (use_idle) begin
               mode_in = MODE_IDLE;
               if (c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE}) begin
                  if (c == CHAR_NEWLINE) begin
                     line_in = line_inc;
                  end
               end else begin
                  case (c)
                     CHAR_COMMA: begin
                        idle_e = 1'b1;
                        idle_r = make_rsp(KIND_COMMA, line_ff, pos_ff, LENGTH_BITS'(1));
                     end
                     CHAR_PERIOD: begin
                        idle_e = 1'b1;
                        idle_r = make_rsp(KIND_PERIOD, line_ff, pos_ff, LENGTH_BITS'(1));
                     end
                     CHAR_QMARK: begin
                        idle_e = 1'b1;
                        idle_r = make_rsp(KIND_QMARK, line_ff, pos_ff, LENGTH_BITS'(1));
                     end
                     CHAR_LPAREN: begin
                        idle_e = 1'b1;
                        idle_r = make_rsp(KIND_LPAREN, line_ff, pos_ff, LENGTH_BITS'(1));
                     end
                     CHAR_RPAREN: begin
                        idle_e = 1'b1;
                        idle_r = make_rsp(KIND_RPAREN, line_ff, pos_ff, LENGTH_BITS'(1));
                     end
                     CHAR_STAR: begin
                        idle_e = 1'b1;
                        idle_r = make_rsp(KIND_MUL, line_ff, pos_ff, LENGTH_BITS'(1));
                     end
                     CHAR_PLUS: begin
                        idle_e = 1'b1;
                        idle_r = make_rsp(KIND_ADD, line_ff, pos_ff, LENGTH_BITS'(1));
                     end
                     CHAR_COLON: begin
                        mode_in  = MODE_COLON;
                        start_in = pos_ff;
                        len_in   = LENGTH_BITS'(1);
                     end
                     CHAR_HASH: begin
                        mode_in = MODE_COMMENT;
                     end
                     CHAR_QUOTE: begin
                        mode_in  = MODE_STRING;
                        start_in = pos_ff;
                        len_in   = LENGTH_BITS'(1);
                     end
                     default: begin
                        if (is_alpha) begin
                           mode_in  = MODE_IDENT;
                           start_in = pos_ff;
                           len_in   = LENGTH_BITS'(1);
                           flags_in = flags_first;
                        end else begin
                           idle_e  = 1'b1;
                           idle_r  = make_rsp(KIND_ERROR, line_ff, pos_ff, '0);
                           mode_in = MODE_STOPPED;
                        end
                     end
                  endcase
               end

               // after a flushed token the idle result takes the second slot
               if (mode_ff != MODE_IDLE) begin
                  e1 = idle_e;
                  r1 = idle_r;
               end else begin
                  e0 = idle_e;
                  r0 = idle_r;
               end
            end
         end
      end

      if (e1) begin
         r1.last_of_item = 1'b1;
      end else if (e0) begin
         r0.last_of_item = 1'b1;
      end
   end

   // result queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrBits'({1'b0, e0} + {1'b0, e1});
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
      count_in  = count_ff + (PtrBits+1)'({1'b0, e0} + {1'b0, e1})
                  - (PtrBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= 16'd1;
         pos_ff    <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         flags_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         flags_ff  <= flags_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e0) begin
         fifo_ff[wr_ptr_ff] <= r0;
      end
      if (e1) begin
         fifo_ff[wr_ptr_ff + PtrBits'(1)] <= r1;
      end
   end

endmodule
